[design/dmr_pkg.sv]
// ----------------------------------------------------------------------------
// dmr_pkg
// Types and constants for the delimited message receiver.
// ----------------------------------------------------------------------------
package dmr_pkg;

  localparam int MAX_CHARS   = 32;
  localparam int IDX_W       = $clog2(MAX_CHARS);
  localparam int ELAPSED_W   = 17;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [IDX_W-1:0]     LAST_SLOT   = IDX_W'(MAX_CHARS - 1);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [7:0]           TERMINATOR  = 8'h00;

  // item modes
  localparam logic [1:0] MODE_TICK        = 2'd0;
  localparam logic [1:0] MODE_BYTE        = 2'd1;
  localparam logic [1:0] MODE_CLR_READY   = 2'd2;
  localparam logic [1:0] MODE_CLR_TIMEOUT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_START  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_CHAR   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS = 8'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic             write_valid;
    logic [IDX_W-1:0] write_index;
    logic [7:0]       write_byte;
    logic             message_done;
    logic             timeout_event;
    logic [IDX_W-1:0] message_length;
    logic             data_ready;
    logic             timed_out;
    logic             receiving;
  } out_item_t;

  typedef struct packed {
    logic        use_start;
    logic [7:0]  start_char;
    logic [7:0]  end_char;
    logic [15:0] timeout_ms;
  } cfg_t;

endpackage

[design/delimited_message_receiver.sv]
// ----------------------------------------------------------------------------
// delimited_message_receiver
// Frames received bytes into end-delimited messages with a tick timeout.
// ----------------------------------------------------------------------------
// Takes one item per cycle while results are taken: an input register feeds
// the framing logic, whose result lands in an output register, from which an
// item's result is offered. Each item yields exactly one result. While a
// result waits to be taken the input register takes one more item, then the
// input stalls until the result goes. Configuration writes are always taken
// and belong between items, with nothing in flight; indexes beyond the
// register list are ignored.
module delimited_message_receiver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dmr_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dmr_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dmr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dmr_pkg::cfg_t      cfg_r;
  dmr_pkg::in_item_t  item_r;
  logic               item_vld_r;
  dmr_pkg::out_item_t result;
  dmr_pkg::out_item_t out_r;
  logic               out_vld_r;
  logic               advance;

  assign cfg_ready = 1'b1;
  assign advance   = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !item_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_start  <= 1'b0;
      cfg_r.start_char <= 8'd0;
      cfg_r.end_char   <= 8'd10;
      cfg_r.timeout_ms <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        dmr_pkg::CFG_USE_START:  cfg_r.use_start  <= cfg_data[0];
        dmr_pkg::CFG_START_CHAR: cfg_r.start_char <= cfg_data[7:0];
        dmr_pkg::CFG_END_CHAR:   cfg_r.end_char   <= cfg_data[7:0];
        dmr_pkg::CFG_TIMEOUT_MS: cfg_r.timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  dmr_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (result)
  );

endmodule

[design/dmr_frame.sv]
// ----------------------------------------------------------------------------
// dmr_frame
// Framing state and per-item result logic; state advances on step.
// ----------------------------------------------------------------------------
module dmr_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  dmr_pkg::in_item_t   item,
  input  dmr_pkg::cfg_t       cfg,
  output dmr_pkg::out_item_t  result
);

  logic [dmr_pkg::IDX_W-1:0]     fill_r, fill_nxt;
  logic                          coll_r, coll_nxt;
  logic                          ready_r, ready_nxt;
  logic                          tout_r, tout_nxt;
  logic [dmr_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;

  always_comb begin
    logic                          coll_v;
    logic [dmr_pkg::ELAPSED_W-1:0] el_v;
    fill_nxt    = fill_r;
    coll_nxt    = coll_r;
    ready_nxt   = ready_r;
    tout_nxt    = tout_r;
    elapsed_nxt = elapsed_r;
    result      = '0;
    coll_v      = coll_r;
    el_v        = elapsed_r;
    case (item.mode)
      dmr_pkg::MODE_TICK: begin
        if (coll_r && elapsed_r != dmr_pkg::ELAPSED_MAX) begin
          el_v = elapsed_r + 1'b1;
        end
        elapsed_nxt = el_v;
        if (coll_r && !ready_r && el_v > {1'b0, cfg.timeout_ms}) begin
          result.write_valid    = 1'b1;
          result.write_index    = fill_r;
          result.write_byte     = dmr_pkg::TERMINATOR;
          result.timeout_event  = 1'b1;
          result.message_length = fill_r;
          fill_nxt = '0;
          coll_nxt = 1'b0;
          tout_nxt = 1'b1;
        end
      end
      dmr_pkg::MODE_BYTE: begin
        if (!cfg.use_start && !coll_r) begin
          coll_v = 1'b1;
          el_v   = '0;
        end
        coll_nxt    = coll_v;
        elapsed_nxt = el_v;
        if (coll_v && item.rx_byte != cfg.end_char) begin
          result.write_valid = 1'b1;
          result.write_index = fill_r;
          result.write_byte  = item.rx_byte;
          fill_nxt = (fill_r == dmr_pkg::LAST_SLOT) ? fill_r : fill_r + 1'b1;
        end else if (coll_v) begin
          result.write_valid    = 1'b1;
          result.write_index    = fill_r;
          result.write_byte     = dmr_pkg::TERMINATOR;
          result.message_done   = 1'b1;
          result.message_length = fill_r;
          fill_nxt  = '0;
          coll_nxt  = 1'b0;
          tout_nxt  = 1'b0;
          ready_nxt = 1'b1;
        end else if (cfg.use_start && item.rx_byte == cfg.start_char) begin
          coll_nxt    = 1'b1;
          elapsed_nxt = '0;
        end
      end
      dmr_pkg::MODE_CLR_READY: begin
        ready_nxt = 1'b0;
      end
      dmr_pkg::MODE_CLR_TIMEOUT: begin
        tout_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    result.data_ready = ready_nxt;
    result.timed_out  = tout_nxt;
    result.receiving  = coll_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      coll_r    <= 1'b0;
      ready_r   <= 1'b0;
      tout_r    <= 1'b0;
      elapsed_r <= '0;
    end else if (step) begin
      fill_r    <= fill_nxt;
      coll_r    <= coll_nxt;
      ready_r   <= ready_nxt;
      tout_r    <= tout_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delimited_message_receiver. Items go in and results
// come out over valid/ready channels with random idle bursts on both sides.
// A scoreboard class frames each accepted item itself, queues the expected
// result and checks every result field by field. Directed items cover empty
// messages, start mode, clear items and timeouts. Random phases send
// well-formed messages with random content, overflow and noise under several
// register settings. A final tick run checks that data-ready holds off the
// timeout until it is cleared.
// ----------------------------------------------------------------------------
import dmr_pkg::*;

class frame_scoreboard;
  logic                 use_start;
  logic [7:0]           start_char;
  logic [7:0]           end_char;
  logic [15:0]          timeout_ms;
  logic [IDX_W-1:0]     fill;
  logic                 collecting;
  logic                 ready_flag;
  logic                 timeout_flag;
  logic [ELAPSED_W-1:0] elapsed;
  out_item_t            pending_frames[$];
  int                   mismatches;

  function new();
    use_start    = 1'b0;
    start_char   = 8'd0;
    end_char     = 8'd10;
    timeout_ms   = 16'd1000;
    fill         = '0;
    collecting   = 1'b0;
    ready_flag   = 1'b0;
    timeout_flag = 1'b0;
    elapsed      = '0;
    mismatches   = 0;
  endfunction

  function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_USE_START:  use_start  = data[0];
      CFG_START_CHAR: start_char = data[7:0];
      CFG_END_CHAR:   end_char   = data[7:0];
      CFG_TIMEOUT_MS: timeout_ms = data[15:0];
      default: ;
    endcase
  endfunction

  function void frame_item(in_item_t it);
    out_item_t e;
    e = '0;
    case (it.mode)
      MODE_TICK: begin
        if (collecting && elapsed != ELAPSED_MAX) elapsed++;
        if (collecting && !ready_flag && elapsed > timeout_ms) begin
          e.write_valid    = 1'b1;
          e.write_index    = fill;
          e.write_byte     = TERMINATOR;
          e.timeout_event  = 1'b1;
          e.message_length = fill;
          fill             = '0;
          collecting       = 1'b0;
          timeout_flag     = 1'b1;
        end
      end
      MODE_BYTE: begin
        if (!use_start && !collecting) begin
          collecting = 1'b1;
          elapsed    = '0;
        end
        if (collecting && it.rx_byte != end_char) begin
          e.write_valid = 1'b1;
          e.write_index = fill;
          e.write_byte  = it.rx_byte;
          if (fill != LAST_SLOT) fill++;
        end else if (collecting) begin
          e.write_valid    = 1'b1;
          e.write_index    = fill;
          e.write_byte     = TERMINATOR;
          e.message_done   = 1'b1;
          e.message_length = fill;
          fill             = '0;
          collecting       = 1'b0;
          timeout_flag     = 1'b0;
          ready_flag       = 1'b1;
        end else if (use_start && it.rx_byte == start_char) begin
          collecting = 1'b1;
          elapsed    = '0;
        end
      end
      MODE_CLR_READY: ready_flag = 1'b0;
      default:        timeout_flag = 1'b0;
    endcase
    e.data_ready = ready_flag;
    e.timed_out  = timeout_flag;
    e.receiving  = collecting;
    pending_frames.push_back(e);
  endfunction

  task report(string what);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task compare_frame(out_item_t got);
    out_item_t e;
    if (pending_frames.size() == 0) begin
      report("result with no item waiting");
      return;
    end
    e = pending_frames.pop_front();
    if (got.write_valid !== e.write_valid)
      report($sformatf("write_valid %0d, want %0d", got.write_valid, e.write_valid));
    if (got.write_index !== e.write_index)
      report($sformatf("write_index %0d, want %0d", got.write_index, e.write_index));
    if (got.write_byte !== e.write_byte)
      report($sformatf("write_byte %0h, want %0h", got.write_byte, e.write_byte));
    if (got.message_done !== e.message_done)
      report($sformatf("message_done %0d, want %0d", got.message_done, e.message_done));
    if (got.timeout_event !== e.timeout_event)
      report($sformatf("timeout_event %0d, want %0d", got.timeout_event, e.timeout_event));
    if (got.message_length !== e.message_length)
      report($sformatf("message_length %0d, want %0d", got.message_length,
                       e.message_length));
    if (got.data_ready !== e.data_ready)
      report($sformatf("data_ready %0d, want %0d", got.data_ready, e.data_ready));
    if (got.timed_out !== e.timed_out)
      report($sformatf("timed_out %0d, want %0d", got.timed_out, e.timed_out));
    if (got.receiving !== e.receiving)
      report($sformatf("receiving %0d, want %0d", got.receiving, e.receiving));
  endtask
endclass

module testbench;
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  frame_scoreboard sb = new();
  bit idle_enable  = 1'b1;
  bit hold_request = 1'b0;
  int items_sent   = 0;
  int stall_left   = 0;

  delimited_message_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.frame_item(in_item);
      if (out_valid && out_ready) sb.compare_frame(out_item);
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (hold_request) begin
          hold_request = 1'b0;
          stall_left   = 150;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 8);
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] mode, logic [7:0] b);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_item.mode    <= mode;
    in_item.rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_frames.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic us, logic [7:0] sc, logic [7:0] ec, logic [15:0] tmo);
    settle();
    write_register(CFG_USE_START, {15'($urandom), us});
    write_register(CFG_START_CHAR, {8'($urandom), sc});
    write_register(CFG_END_CHAR, {8'($urandom), ec});
    write_register(CFG_TIMEOUT_MS, tmo);
  endtask

  task automatic send_message();
    int len;
    int n;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) send_item(2'($urandom), 8'($urandom));
    if (sb.use_start) send_item(MODE_BYTE, sb.start_char);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) send_item(MODE_TICK, 8'($urandom));
      b = 8'($urandom);
      if (b == sb.end_char) b = b ^ 8'h01;
      send_item(MODE_BYTE, b);
    end
    if ($urandom_range(0, 5) == 0) begin
      n = (sb.timeout_ms <= 40) ? sb.timeout_ms + $urandom_range(1, 3) : 3;
      repeat (n) send_item(MODE_TICK, 8'($urandom));
    end else begin
      send_item(MODE_BYTE, sb.end_char);
    end
    if ($urandom_range(0, 2) == 0) send_item(MODE_CLR_READY, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_item(MODE_CLR_TIMEOUT, 8'($urandom));
  endtask

  task automatic run_random(int count, bit with_hold);
    bit held;
    held       = 1'b0;
    items_sent = 0;
    while (items_sent < count) begin
      if (with_hold && !held && items_sent > count / 2) begin
        hold_request = 1'b1;
        held         = 1'b1;
      end
      send_message();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no start char, end 10, timeout 1000
    send_item(MODE_TICK, 8'hFF);
    send_item(MODE_CLR_READY, 8'h00);
    send_item(MODE_CLR_TIMEOUT, 8'hAA);
    send_item(MODE_BYTE, 8'd10);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h41);
    send_item(MODE_BYTE, 8'd10);
    send_item(MODE_BYTE, 8'h55);
    send_item(MODE_BYTE, 8'd10);
    send_item(MODE_CLR_READY, 8'h55);
    settle();
    write_register(8'd4, 16'hFFFF);
    write_register(8'hFF, 16'h1234);
    write_register(CFG_TIMEOUT_MS, 16'd0);
    send_item(MODE_BYTE, 8'h33);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_CLR_TIMEOUT, 8'h00);
    settle();
    write_register(CFG_USE_START, 16'd1);
    write_register(CFG_START_CHAR, 16'h0002);
    send_item(MODE_BYTE, 8'h41);
    send_item(MODE_BYTE, 8'h02);
    send_item(MODE_BYTE, 8'h02);
    send_item(MODE_BYTE, 8'h41);
    send_item(MODE_BYTE, 8'd10);

    configure(1'b1, 8'h02, 8'h03, 16'd5);
    run_random(320, 1'b1);
    configure(1'b0, 8'hFF, 8'h00, 16'd0);
    run_random(320, 1'b0);
    configure(1'b1, 8'h00, 8'hFF, 16'd12);
    run_random(320, 1'b0);
    configure(1'b1, 8'($urandom), 8'($urandom), 16'($urandom_range(1, 30)));
    run_random(320, 1'b0);
    settle();
    idle_enable = 1'b0;
    configure(1'b0, 8'($urandom), 8'($urandom), 16'hFFFF);
    run_random(320, 1'b0);

    // data-ready holds off the timeout until it is cleared
    configure(1'b0, 8'h00, 8'd10, 16'd2);
    send_item(MODE_BYTE, 8'h41);
    send_item(MODE_BYTE, 8'd10);
    send_item(MODE_BYTE, 8'h42);
    repeat (8) send_item(MODE_TICK, 8'($urandom));
    send_item(MODE_CLR_READY, 8'h00);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_CLR_TIMEOUT, 8'h00);

    settle();
    repeat (8) @(posedge clk);
    if (sb.pending_frames.size() != 0) sb.report("expected results left over");
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
